FILE: rtl/core/wlan_info_element_parser_assert.svh
// Assertion helpers; the enclosing module provides clk and rst_n.
`ifndef WLAN_INFO_ELEMENT_PARSER_ASSERT_SVH
`define WLAN_INFO_ELEMENT_PARSER_ASSERT_SVH

// Same-cycle implication.
`define WIEP_ASSERT_IMPL(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("wlan ie parser: assertion failed");

// Next-cycle implication.
`define WIEP_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("wlan ie parser: assertion failed");

`endif

FILE: rtl/core/wlan_ie_pkg.sv
package wlan_ie_pkg;

    localparam int MAX_BODY_BYTES_DEF = 4096;
    localparam int BODY_LEN_W         = 12;

    // configuration register indexes
    localparam logic [2:0] CFG_SSID_ID    = 3'd0;
    localparam logic [2:0] CFG_RATES_ID   = 3'd1;
    localparam logic [2:0] CFG_COUNTRY_ID = 3'd2;
    localparam logic [2:0] CFG_TRAFFIC_ID = 3'd3;
    localparam logic [2:0] CFG_SECURE_ID  = 3'd4;
    localparam logic [2:0] CFG_STD_OUI    = 3'd5;

    localparam logic [7:0]  SSID_ID_RST    = 8'd0;
    localparam logic [7:0]  RATES_ID_RST   = 8'd1;
    localparam logic [7:0]  COUNTRY_ID_RST = 8'd7;
    localparam logic [7:0]  TRAFFIC_ID_RST = 8'd5;
    localparam logic [7:0]  SECURE_ID_RST  = 8'd48;
    localparam logic [23:0] STD_OUI_RST    = 24'h000FAC;

    // parse phases
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_TYPE  = 3'd1;
    localparam logic [2:0] PH_LEN   = 3'd2;
    localparam logic [2:0] PH_VALUE = 3'd3;
    localparam logic [2:0] PH_SKIP  = 3'd4;

    // RSN sub-phases
    localparam logic [2:0] SP_SKIP       = 3'd0;
    localparam logic [2:0] SP_PAIR_COUNT = 3'd1;
    localparam logic [2:0] SP_PAIR_SUITE = 3'd2;
    localparam logic [2:0] SP_AKM_COUNT  = 3'd3;
    localparam logic [2:0] SP_AKM_SUITE  = 3'd4;
    localparam logic [2:0] SP_STOP       = 3'd5;

    // element classes
    localparam logic [2:0] CL_SSID     = 3'd0;
    localparam logic [2:0] CL_RATES    = 3'd1;
    localparam logic [2:0] CL_COUNTRY  = 3'd2;
    localparam logic [2:0] CL_SECURITY = 3'd3;
    localparam logic [2:0] CL_TRAFFIC  = 3'd4;
    localparam logic [2:0] CL_OTHER    = 3'd5;

    // record kinds
    localparam logic [3:0] KIND_SSID       = 4'd0;
    localparam logic [3:0] KIND_RATE       = 4'd1;
    localparam logic [3:0] KIND_COUNTRY    = 4'd2;
    localparam logic [3:0] KIND_PAIRWISE   = 4'd3;
    localparam logic [3:0] KIND_AKM        = 4'd4;
    localparam logic [3:0] KIND_DTIM_COUNT = 4'd5;
    localparam logic [3:0] KIND_DTIM_LEN   = 4'd8;
    localparam logic [3:0] KIND_PAIR_ERR   = 4'd9;
    localparam logic [3:0] KIND_AKM_ERR    = 4'd10;

    localparam logic [7:0] DTIM_LEN      = 8'd3;
    localparam logic [7:0] RATE_MASK     = 8'h7F;
    localparam logic [7:0] RSN_HDR_BYTES = 8'd6;
    localparam logic [7:0] SUITE_BYTES   = 8'd4;
    localparam logic [7:0] OFFSET_MAX    = 8'd255;

    typedef struct packed {
        logic [3:0]  kind;
        logic [7:0]  value;
        logic [23:0] oui;
        logic        match;
        logic        known;
    } record_t;

    function automatic logic suite_type_known(input logic akm, input logic [7:0] t);
        logic res;
        if (akm)
            res = (t >= 8'd1) && (t <= 8'd18) && (t != 8'd10);
        else
            res = (t <= 8'd8) && (t != 8'd3);
        return res;
    endfunction

endpackage

FILE: rtl/core/wlan_info_element_parser.sv
// A record is registered into the result register, or into the skid when that is still held.
// Throughput: one body byte per cycle while in_ready is high; all parsing is a single registered step.
// A two-entry output (result register plus skid) keeps input flowing while a
// record waits; in_ready drops only when both entries hold records.
// Reset (rst_n low, asynchronous): parser idle, outputs empty, element ids and
// standard OUI back to their defaults.
`include "wlan_info_element_parser_assert.svh"

module wlan_info_element_parser #(
    parameter int MAX_BODY_BYTES = wlan_ie_pkg::MAX_BODY_BYTES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [7:0]                        body_byte,
    input  logic                              first_byte,
    input  logic [wlan_ie_pkg::BODY_LEN_W-1:0] body_length,

    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [3:0]                        record_kind,
    output logic [7:0]                        record_value,
    output logic [23:0]                       suite_oui,
    output logic                              oui_matches,
    output logic                              suite_known,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [2:0]                        cfg_index,
    input  logic [23:0]                       cfg_data
);

    localparam int BL_W  = $clog2(MAX_BODY_BYTES + 1);
    localparam int CMP_W = (BL_W > wlan_ie_pkg::BODY_LEN_W) ? BL_W : wlan_ie_pkg::BODY_LEN_W;

    // configuration
    logic [7:0]  ssid_id_reg, rates_id_reg, country_id_reg, traffic_id_reg, secure_id_reg;
    logic [23:0] std_oui_reg;

    // parser state
    logic [BL_W-1:0] bytes_left_reg,   bytes_left_next;
    logic [2:0]      phase_reg,        phase_next;
    logic [7:0]      element_type_reg, element_type_next;
    logic [7:0]      element_left_reg, element_left_next;
    logic [7:0]      value_offset_reg, value_offset_next;
    logic [15:0]     suite_count_reg,  suite_count_next;
    logic [31:0]     suite_bytes_reg,  suite_bytes_next;
    logic [2:0]      sec_phase_reg,    sec_phase_next;

    // output stage
    wlan_ie_pkg::record_t out_reg, skid_reg, rec_next;
    logic                 out_valid_reg, skid_valid_reg;
    logic                 emit;

    logic in_fire, out_fire;
    logic [2:0] el_class;
    logic [CMP_W-1:0] len_ext, len_sat;
    logic [BL_W-1:0]  room;
    logic [7:0]       after;
    logic [15:0]      count_val;
    logic [17:0]      count_bytes;
    logic [31:0]      suite_shift;
    logic             is_akm;

    assign in_ready  = !skid_valid_reg;
    assign cfg_ready = 1'b1;
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid_reg && out_ready;

    assign out_valid    = out_valid_reg;
    assign record_kind  = out_reg.kind;
    assign record_value = out_reg.value;
    assign suite_oui    = out_reg.oui;
    assign oui_matches  = out_reg.match;
    assign suite_known  = out_reg.known;

    // priority order: ssid, rates, country, security, traffic map
    always_comb
    begin
        if (element_type_reg == ssid_id_reg)
            el_class = wlan_ie_pkg::CL_SSID;
        else if (element_type_reg == rates_id_reg)
            el_class = wlan_ie_pkg::CL_RATES;
        else if (element_type_reg == country_id_reg)
            el_class = wlan_ie_pkg::CL_COUNTRY;
        else if (element_type_reg == secure_id_reg)
            el_class = wlan_ie_pkg::CL_SECURITY;
        else if (element_type_reg == traffic_id_reg)
            el_class = wlan_ie_pkg::CL_TRAFFIC;
        else
            el_class = wlan_ie_pkg::CL_OTHER;
    end

    assign len_ext     = CMP_W'(body_length);
    assign len_sat     = (len_ext > CMP_W'(MAX_BODY_BYTES)) ? CMP_W'(MAX_BODY_BYTES) : len_ext;
    assign room        = bytes_left_reg - BL_W'(1);
    assign after       = element_left_reg - 8'd1;
    assign count_val   = {body_byte, suite_bytes_reg[7:0]};
    assign count_bytes = {count_val, 2'b00};
    assign suite_shift = {suite_bytes_reg[23:0], body_byte};
    assign is_akm      = (sec_phase_reg == wlan_ie_pkg::SP_AKM_SUITE);

    always_comb
    begin
        bytes_left_next   = bytes_left_reg;
        phase_next        = phase_reg;
        element_type_next = element_type_reg;
        element_left_next = element_left_reg;
        value_offset_next = value_offset_reg;
        suite_count_next  = suite_count_reg;
        suite_bytes_next  = suite_bytes_reg;
        sec_phase_next    = sec_phase_reg;
        emit              = 1'b0;
        rec_next          = '0;

        if (in_fire)
        begin
            if (first_byte)
            begin
                bytes_left_next   = BL_W'(len_sat);
                phase_next        = wlan_ie_pkg::PH_TYPE;
                element_type_next = '0;
                element_left_next = '0;
                value_offset_next = '0;
                suite_count_next  = '0;
                suite_bytes_next  = '0;
                sec_phase_next    = wlan_ie_pkg::SP_SKIP;
            end

            if (phase_next != wlan_ie_pkg::PH_IDLE)
            begin
                if (bytes_left_next == '0)
                begin
                    phase_next = wlan_ie_pkg::PH_IDLE;
                end
                else
                begin
                    case (phase_next)
                        wlan_ie_pkg::PH_TYPE:
                        begin
                            if (bytes_left_next > BL_W'(2))
                            begin
                                element_type_next = body_byte;
                                phase_next        = wlan_ie_pkg::PH_LEN;
                            end
                            else
                                phase_next = wlan_ie_pkg::PH_IDLE;
                        end
                        wlan_ie_pkg::PH_LEN:
                        begin
                            // truncate element at body end
                            element_left_next = (BL_W'(body_byte) < room) ? body_byte : room[7:0];
                            value_offset_next = '0;
                            suite_count_next  = '0;
                            suite_bytes_next  = '0;
                            sec_phase_next    = wlan_ie_pkg::SP_SKIP;
                            if (el_class == wlan_ie_pkg::CL_TRAFFIC &&
                                body_byte != wlan_ie_pkg::DTIM_LEN)
                            begin
                                emit           = 1'b1;
                                rec_next.kind  = wlan_ie_pkg::KIND_DTIM_LEN;
                                rec_next.value = body_byte;
                                phase_next     = wlan_ie_pkg::PH_SKIP;
                            end
                            else
                                phase_next = wlan_ie_pkg::PH_VALUE;
                            if (element_left_next == '0)
                                phase_next = wlan_ie_pkg::PH_TYPE;
                        end
                        wlan_ie_pkg::PH_VALUE, wlan_ie_pkg::PH_SKIP:
                        begin
                            if (phase_reg == wlan_ie_pkg::PH_VALUE)
                            begin
                                case (el_class)
                                    wlan_ie_pkg::CL_SSID:
                                    begin
                                        emit           = 1'b1;
                                        rec_next.kind  = wlan_ie_pkg::KIND_SSID;
                                        rec_next.value = body_byte;
                                    end
                                    wlan_ie_pkg::CL_RATES:
                                    begin
                                        emit           = 1'b1;
                                        rec_next.kind  = wlan_ie_pkg::KIND_RATE;
                                        rec_next.value = body_byte & wlan_ie_pkg::RATE_MASK;
                                    end
                                    wlan_ie_pkg::CL_COUNTRY:
                                    begin
                                        if (value_offset_reg < 8'd2)
                                        begin
                                            emit           = 1'b1;
                                            rec_next.kind  = wlan_ie_pkg::KIND_COUNTRY;
                                            rec_next.value = body_byte;
                                        end
                                    end
                                    wlan_ie_pkg::CL_TRAFFIC:
                                    begin
                                        if (value_offset_reg < 8'd3)
                                        begin
                                            emit           = 1'b1;
                                            rec_next.kind  = wlan_ie_pkg::KIND_DTIM_COUNT +
                                                             value_offset_reg[3:0];
                                            rec_next.value = body_byte;
                                        end
                                    end
                                    wlan_ie_pkg::CL_SECURITY:
                                    begin
                                        case (sec_phase_reg)
                                            wlan_ie_pkg::SP_SKIP:
                                            begin
                                                // version and group cipher
                                                value_offset_next = value_offset_reg + 8'd1;
                                                if (value_offset_next >= wlan_ie_pkg::RSN_HDR_BYTES)
                                                begin
                                                    sec_phase_next    = wlan_ie_pkg::SP_PAIR_COUNT;
                                                    value_offset_next = '0;
                                                end
                                            end
                                            wlan_ie_pkg::SP_PAIR_COUNT,
                                            wlan_ie_pkg::SP_AKM_COUNT:
                                            begin
                                                if (value_offset_reg == '0)
                                                begin
                                                    suite_bytes_next  = {24'd0, body_byte};
                                                    value_offset_next = 8'd1;
                                                end
                                                else
                                                begin
                                                    value_offset_next = '0;
                                                    suite_bytes_next  = '0;
                                                    if (count_bytes > 18'(after))
                                                    begin
                                                        emit           = 1'b1;
                                                        rec_next.value = count_val[7:0];
                                                        if (sec_phase_reg == wlan_ie_pkg::SP_PAIR_COUNT)
                                                        begin
                                                            rec_next.kind    = wlan_ie_pkg::KIND_PAIR_ERR;
                                                            suite_count_next = count_val;
                                                            sec_phase_next   = wlan_ie_pkg::SP_PAIR_SUITE;
                                                        end
                                                        else
                                                        begin
                                                            rec_next.kind  = wlan_ie_pkg::KIND_AKM_ERR;
                                                            sec_phase_next = wlan_ie_pkg::SP_STOP;
                                                        end
                                                    end
                                                    else if (count_val == '0)
                                                    begin
                                                        sec_phase_next =
                                                            (sec_phase_reg == wlan_ie_pkg::SP_PAIR_COUNT) ?
                                                            wlan_ie_pkg::SP_AKM_COUNT : wlan_ie_pkg::SP_STOP;
                                                    end
                                                    else
                                                    begin
                                                        suite_count_next = count_val;
                                                        sec_phase_next =
                                                            (sec_phase_reg == wlan_ie_pkg::SP_PAIR_COUNT) ?
                                                            wlan_ie_pkg::SP_PAIR_SUITE : wlan_ie_pkg::SP_AKM_SUITE;
                                                    end
                                                end
                                            end
                                            wlan_ie_pkg::SP_PAIR_SUITE,
                                            wlan_ie_pkg::SP_AKM_SUITE:
                                            begin
                                                suite_bytes_next  = suite_shift;
                                                value_offset_next = value_offset_reg + 8'd1;
                                                if (value_offset_next >= wlan_ie_pkg::SUITE_BYTES)
                                                begin
                                                    emit           = 1'b1;
                                                    rec_next.kind  = is_akm ? wlan_ie_pkg::KIND_AKM :
                                                                     wlan_ie_pkg::KIND_PAIRWISE;
                                                    rec_next.value = suite_shift[7:0];
                                                    rec_next.oui   = suite_shift[31:8];
                                                    rec_next.match = (suite_shift[31:8] == std_oui_reg);
                                                    rec_next.known = rec_next.match &&
                                                        wlan_ie_pkg::suite_type_known(is_akm,
                                                                                      suite_shift[7:0]);
                                                    value_offset_next = '0;
                                                    suite_bytes_next  = '0;
                                                    suite_count_next  = suite_count_reg - 16'd1;
                                                    if (suite_count_next == '0)
                                                        sec_phase_next = is_akm ? wlan_ie_pkg::SP_STOP :
                                                                         wlan_ie_pkg::SP_AKM_COUNT;
                                                end
                                            end
                                            default:
                                            begin
                                            end
                                        endcase
                                    end
                                    default:
                                    begin
                                    end
                                endcase
                                if (el_class != wlan_ie_pkg::CL_SECURITY &&
                                    value_offset_reg < wlan_ie_pkg::OFFSET_MAX)
                                    value_offset_next = value_offset_reg + 8'd1;
                            end
                            element_left_next = after;
                            if (after == '0)
                                phase_next = wlan_ie_pkg::PH_TYPE;
                        end
                        default:
                        begin
                            phase_next = wlan_ie_pkg::PH_IDLE;
                        end
                    endcase

                    bytes_left_next = bytes_left_next - BL_W'(1);
                    if (bytes_left_next == '0)
                        phase_next = wlan_ie_pkg::PH_IDLE;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ssid_id_reg    <= wlan_ie_pkg::SSID_ID_RST;
            rates_id_reg   <= wlan_ie_pkg::RATES_ID_RST;
            country_id_reg <= wlan_ie_pkg::COUNTRY_ID_RST;
            traffic_id_reg <= wlan_ie_pkg::TRAFFIC_ID_RST;
            secure_id_reg  <= wlan_ie_pkg::SECURE_ID_RST;
            std_oui_reg    <= wlan_ie_pkg::STD_OUI_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                wlan_ie_pkg::CFG_SSID_ID:    ssid_id_reg    <= cfg_data[7:0];
                wlan_ie_pkg::CFG_RATES_ID:   rates_id_reg   <= cfg_data[7:0];
                wlan_ie_pkg::CFG_COUNTRY_ID: country_id_reg <= cfg_data[7:0];
                wlan_ie_pkg::CFG_TRAFFIC_ID: traffic_id_reg <= cfg_data[7:0];
                wlan_ie_pkg::CFG_SECURE_ID:  secure_id_reg  <= cfg_data[7:0];
                wlan_ie_pkg::CFG_STD_OUI:    std_oui_reg    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg   <= '0;
            phase_reg        <= wlan_ie_pkg::PH_IDLE;
            element_type_reg <= '0;
            element_left_reg <= '0;
            value_offset_reg <= '0;
            suite_count_reg  <= '0;
            suite_bytes_reg  <= '0;
            sec_phase_reg    <= wlan_ie_pkg::SP_SKIP;
        end
        else
        begin
            bytes_left_reg   <= bytes_left_next;
            phase_reg        <= phase_next;
            element_type_reg <= element_type_next;
            element_left_reg <= element_left_next;
            value_offset_reg <= value_offset_next;
            suite_count_reg  <= suite_count_next;
            suite_bytes_reg  <= suite_bytes_next;
            sec_phase_reg    <= sec_phase_next;
        end
    end

    // output register with skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
                skid_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            if (!out_valid_reg || out_fire)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
                out_reg <= skid_reg;
        end
        else if (emit)
        begin
            if (!out_valid_reg || out_fire)
                out_reg <= rec_next;
            else
                skid_reg <= rec_next;
        end
    end

    `WIEP_ASSERT_IMPL(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    `WIEP_ASSERT_IMPL(a_nonsuite_fields_zero, out_valid_reg && out_reg.kind != wlan_ie_pkg::KIND_PAIRWISE && out_reg.kind != wlan_ie_pkg::KIND_AKM, out_reg.oui == '0 && !out_reg.match && !out_reg.known)
    `WIEP_ASSERT_IMPL(a_known_needs_match, out_valid_reg && out_reg.known, out_reg.match)
    `WIEP_ASSERT_IMPL(a_value_has_bytes, phase_reg == wlan_ie_pkg::PH_VALUE || phase_reg == wlan_ie_pkg::PH_SKIP, element_left_reg != '0)
    `WIEP_ASSERT_NEXT(a_first_byte_is_type, in_fire && first_byte && body_length > 12'd3, phase_reg == wlan_ie_pkg::PH_LEN)

endmodule

FILE: test/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wlan_ie_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 40;
    localparam int DRAIN_CYCLES = 4;
    localparam int SHOW_MAX     = 10;

    // Expected-record store plus a cycle-free model of the element walker.
    class ie_record_board;
        record_t     expected_records[$];
        int          failures;
        logic [7:0]  elem_id [5];
        logic [23:0] std_oui;
        int          body_left;
        logic [2:0]  parse_state;
        logic [7:0]  elem_type;
        int          elem_left;
        int          voff;
        logic [15:0] suites_left;
        logic [31:0] suite_acc;
        logic [2:0]  rsn_state;

        function new();
            elem_id[CFG_SSID_ID]    = SSID_ID_RST;
            elem_id[CFG_RATES_ID]   = RATES_ID_RST;
            elem_id[CFG_COUNTRY_ID] = COUNTRY_ID_RST;
            elem_id[CFG_TRAFFIC_ID] = TRAFFIC_ID_RST;
            elem_id[CFG_SECURE_ID]  = SECURE_ID_RST;
            std_oui     = STD_OUI_RST;
            failures    = 0;
            body_left   = 0;
            parse_state = PH_IDLE;
            elem_type   = '0;
            elem_left   = 0;
            voff        = 0;
            suites_left = '0;
            suite_acc   = '0;
            rsn_state   = SP_SKIP;
        endfunction

        function void set_register(logic [2:0] idx, logic [23:0] data);
            case (idx)
                CFG_SSID_ID, CFG_RATES_ID, CFG_COUNTRY_ID, CFG_TRAFFIC_ID, CFG_SECURE_ID:
                    elem_id[idx] = data[7:0];
                CFG_STD_OUI:
                    std_oui = data;
                default: ;
            endcase
        endfunction

        // ssid, rates, country, security, traffic map: first hit wins
        function logic [2:0] class_of(logic [7:0] t);
            if (t == elem_id[CFG_SSID_ID])    return CL_SSID;
            if (t == elem_id[CFG_RATES_ID])   return CL_RATES;
            if (t == elem_id[CFG_COUNTRY_ID]) return CL_COUNTRY;
            if (t == elem_id[CFG_SECURE_ID])  return CL_SECURITY;
            if (t == elem_id[CFG_TRAFFIC_ID]) return CL_TRAFFIC;
            return CL_OTHER;
        endfunction

        function record_t plain_record(logic [3:0] kind, logic [7:0] value);
            record_t rec;
            rec = '0;
            rec.kind  = kind;
            rec.value = value;
            return rec;
        endfunction

        function record_t suite_record(bit akm);
            record_t    rec;
            logic [7:0] t;
            bit         named;
            t = suite_acc[7:0];
            if (akm)
                named = (t >= 8'd1) && (t <= 8'd18) && (t != 8'd10);
            else
                named = (t <= 8'd8) && (t != 8'd3);
            rec.kind  = akm ? KIND_AKM : KIND_PAIRWISE;
            rec.value = t;
            rec.oui   = suite_acc[31:8];
            rec.match = (suite_acc[31:8] == std_oui);
            rec.known = rec.match && named;
            return rec;
        endfunction

        function bit rsn_byte(logic [7:0] b, int after, output record_t rec);
            bit hit;
            bit pair;
            bit akm;
            int cnt;
            hit = 0;
            rec = '0;
            case (rsn_state)
                SP_SKIP: begin
                    voff++;
                    if (voff >= RSN_HDR_BYTES) begin
                        rsn_state = SP_PAIR_COUNT;
                        voff = 0;
                    end
                end
                SP_PAIR_COUNT, SP_AKM_COUNT: begin
                    if (voff == 0) begin
                        suite_acc = {24'd0, b};
                        voff = 1;
                    end else begin
                        cnt = {b, suite_acc[7:0]};
                        pair = (rsn_state == SP_PAIR_COUNT);
                        voff = 0;
                        suite_acc = '0;
                        if (4 * cnt > after) begin
                            hit = 1;
                            if (pair) begin
                                rec = plain_record(KIND_PAIR_ERR, cnt[7:0]);
                                suites_left = cnt[15:0];
                                rsn_state = SP_PAIR_SUITE;
                            end else begin
                                rec = plain_record(KIND_AKM_ERR, cnt[7:0]);
                                rsn_state = SP_STOP;
                            end
                        end else if (cnt == 0) begin
                            rsn_state = pair ? SP_AKM_COUNT : SP_STOP;
                        end else begin
                            suites_left = cnt[15:0];
                            rsn_state = pair ? SP_PAIR_SUITE : SP_AKM_SUITE;
                        end
                    end
                end
                SP_PAIR_SUITE, SP_AKM_SUITE: begin
                    suite_acc = {suite_acc[23:0], b};
                    voff++;
                    if (voff >= SUITE_BYTES) begin
                        akm = (rsn_state == SP_AKM_SUITE);
                        rec = suite_record(akm);
                        hit = 1;
                        voff = 0;
                        suite_acc = '0;
                        suites_left = suites_left - 16'd1;
                        if (suites_left == 0)
                            rsn_state = akm ? SP_STOP : SP_AKM_COUNT;
                    end
                end
                default: ;
            endcase
            return hit;
        endfunction

        function void take_byte(logic [7:0] b, logic first, logic [BODY_LEN_W-1:0] len);
            record_t rec;
            bit      hit;
            int      after;
            int      room;
            hit = 0;
            rec = '0;
            if (first) begin
                body_left   = (len > MAX_BODY_BYTES_DEF) ? MAX_BODY_BYTES_DEF : len;
                parse_state = PH_TYPE;
                elem_type   = '0;
                elem_left   = 0;
                voff        = 0;
                suites_left = '0;
                suite_acc   = '0;
                rsn_state   = SP_SKIP;
            end
            if (parse_state == PH_IDLE)
                return;
            if (body_left == 0) begin
                parse_state = PH_IDLE;
                return;
            end
            case (parse_state)
                PH_TYPE: begin
                    if (body_left > 2) begin
                        elem_type = b;
                        parse_state = PH_LEN;
                    end else begin
                        parse_state = PH_IDLE;
                    end
                end
                PH_LEN: begin
                    room = body_left - 1;
                    elem_left = (b < room) ? b : room;
                    voff = 0;
                    suites_left = '0;
                    suite_acc = '0;
                    rsn_state = SP_SKIP;
                    if (class_of(elem_type) == CL_TRAFFIC && b != DTIM_LEN) begin
                        rec = plain_record(KIND_DTIM_LEN, b);
                        hit = 1;
                        parse_state = PH_SKIP;
                    end else begin
                        parse_state = PH_VALUE;
                    end
                    if (elem_left == 0)
                        parse_state = PH_TYPE;
                end
                PH_VALUE, PH_SKIP: begin
                    after = elem_left - 1;
                    if (parse_state == PH_VALUE) begin
                        case (class_of(elem_type))
                            CL_SSID: begin
                                rec = plain_record(KIND_SSID, b);
                                hit = 1;
                            end
                            CL_RATES: begin
                                rec = plain_record(KIND_RATE, b & RATE_MASK);
                                hit = 1;
                            end
                            CL_COUNTRY: begin
                                if (voff < 2) begin
                                    rec = plain_record(KIND_COUNTRY, b);
                                    hit = 1;
                                end
                            end
                            CL_TRAFFIC: begin
                                if (voff < 3) begin
                                    rec = plain_record(KIND_DTIM_COUNT + voff[3:0], b);
                                    hit = 1;
                                end
                            end
                            CL_SECURITY: hit = rsn_byte(b, after, rec);
                            default: ;
                        endcase
                        if (class_of(elem_type) != CL_SECURITY && voff < OFFSET_MAX)
                            voff++;
                    end
                    elem_left = after;
                    if (elem_left == 0)
                        parse_state = PH_TYPE;
                end
                default: parse_state = PH_IDLE;
            endcase
            body_left--;
            if (body_left == 0)
                parse_state = PH_IDLE;
            if (hit)
                expected_records.push_back(rec);
        endfunction

        function void check_record(record_t got);
            record_t want;
            if (expected_records.size() == 0) begin
                failures++;
                if (failures <= SHOW_MAX)
                    $display("unexpected record: kind %0d value %02h oui %06h match %0b known %0b",
                             got.kind, got.value, got.oui, got.match, got.known);
                return;
            end
            want = expected_records.pop_front();
            if (got !== want) begin
                failures++;
                if (failures <= SHOW_MAX)
                    $display({"record mismatch: expected kind %0d value %02h oui %06h ",
                              "match %0b known %0b, got kind %0d value %02h oui %06h ",
                              "match %0b known %0b"},
                             want.kind, want.value, want.oui, want.match, want.known,
                             got.kind, got.value, got.oui, got.match, got.known);
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [7:0]            body_byte = '0;
    logic                  first_byte = 1'b0;
    logic [BODY_LEN_W-1:0] body_length = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [3:0]            record_kind;
    logic [7:0]            record_value;
    logic [23:0]           suite_oui;
    logic                  oui_matches;
    logic                  suite_known;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [2:0]            cfg_index = '0;
    logic [23:0]           cfg_data = '0;

    ie_record_board sb = new();

    logic [7:0]  frame_q[$];
    logic [7:0]  elem_q[$];
    logic [7:0]  reg_id [5];
    logic [23:0] reg_oui;
    int          items_sent = 0;
    bit          in_idle_on = 1'b1;
    bit          out_idle_on = 1'b1;
    bit          hold_req = 1'b0;

    always #5ns clk = ~clk;

    wlan_info_element_parser u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .body_byte    (body_byte),
        .first_byte   (first_byte),
        .body_length  (body_length),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .record_kind  (record_kind),
        .record_value (record_value),
        .suite_oui    (suite_oui),
        .oui_matches  (oui_matches),
        .suite_known  (suite_known),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // beat monitor: output first, a record never belongs to the byte of the same edge
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready)
                sb.check_record('{kind: record_kind, value: record_value, oui: suite_oui,
                                  match: oui_matches, known: suite_known});
            if (in_valid && in_ready)
                sb.take_byte(body_byte, first_byte, body_length);
            if (cfg_valid && cfg_ready)
                sb.set_register(cfg_index, cfg_data);
        end
    end

    // receiver: random stalls, or one long hold-off when asked
    initial begin
        wait (rst_n);
        forever begin
            @(negedge clk);
            if (hold_req) begin
                out_ready <= 1'b0;
                hold_req = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end else begin
                out_ready <= !out_idle_on || ($urandom_range(99) >= 13);
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // entered and left just after a falling edge
    task automatic send_byte(logic [7:0] b, logic first, logic [BODY_LEN_W-1:0] len);
        while (in_idle_on && $urandom_range(99) < 13) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        body_byte   <= b;
        first_byte  <= first;
        body_length <= len;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic write_reg(logic [2:0] idx, logic [23:0] data);
        while (sb.expected_records.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_STD_OUI)
            reg_oui = data;
        else
            reg_id[idx] = data[7:0];
    endtask

    task automatic configure(logic [7:0] ssid, logic [7:0] rates, logic [7:0] country,
                             logic [7:0] traffic, logic [7:0] secure, logic [23:0] oui);
        in_valid <= 1'b0;
        write_reg(CFG_SSID_ID, {16'd0, ssid});
        write_reg(CFG_RATES_ID, {16'd0, rates});
        write_reg(CFG_COUNTRY_ID, {16'd0, country});
        write_reg(CFG_TRAFFIC_ID, {16'd0, traffic});
        write_reg(CFG_SECURE_ID, {16'd0, secure});
        write_reg(CFG_STD_OUI, oui);
    endtask

    function automatic void fill_random(int n);
        repeat (n) elem_q.push_back(8'($urandom()));
    endfunction

    function automatic void push_count(int n);
        elem_q.push_back(n[7:0]);
        elem_q.push_back(n[15:8]);
    endfunction

    function automatic void push_suite();
        logic [23:0] oui;
        logic [7:0]  t;
        oui = ($urandom_range(3) != 0) ? reg_oui : 24'($urandom());
        t = ($urandom_range(4) != 0) ? 8'($urandom_range(20)) : 8'($urandom());
        elem_q.push_back(oui[23:16]);
        elem_q.push_back(oui[15:8]);
        elem_q.push_back(oui[7:0]);
        elem_q.push_back(t);
    endfunction

    // version, group cipher, pairwise list, AKM list; now and then a bad count or trailing bytes
    function automatic void build_rsn();
        int n_pair;
        int n_akm;
        int flaw;
        n_pair = $urandom_range(3);
        n_akm = $urandom_range(3);
        flaw = $urandom_range(9);
        fill_random(6);
        if (flaw == 0)
            push_count($urandom_range(65535));
        else if (flaw == 1)
            push_count(n_pair + 1);
        else
            push_count(n_pair);
        repeat (n_pair) push_suite();
        if (flaw == 2)
            push_count($urandom_range(65535));
        else if (flaw == 3)
            push_count(n_akm + 1);
        else
            push_count(n_akm);
        repeat (n_akm) push_suite();
        if (flaw == 4)
            fill_random($urandom_range(1, 5));
    endfunction

    function automatic void add_element(logic [7:0] id, int len);
        frame_q.push_back(id);
        frame_q.push_back(len[7:0]);
        foreach (elem_q[i]) frame_q.push_back(elem_q[i]);
    endfunction

    function automatic void add_random_element();
        int len;
        elem_q.delete();
        case ($urandom_range(9))
            0, 1: begin
                fill_random($urandom_range(32));
                add_element(reg_id[CFG_SSID_ID], elem_q.size());
            end
            2: begin
                fill_random($urandom_range(1, 8));
                add_element(reg_id[CFG_RATES_ID], elem_q.size());
            end
            3: begin
                fill_random(($urandom_range(2) != 0) ? 3 : $urandom_range(6));
                add_element(reg_id[CFG_COUNTRY_ID], elem_q.size());
            end
            4: begin
                fill_random(($urandom_range(3) != 0) ? 3 : $urandom_range(6));
                add_element(reg_id[CFG_TRAFFIC_ID], elem_q.size());
            end
            5, 6, 7: begin
                build_rsn();
                len = elem_q.size();
                // short declared length: element ends inside the header or a list
                if ($urandom_range(4) == 0)
                    len = $urandom_range(len);
                add_element(reg_id[CFG_SECURE_ID], len);
            end
            default: begin
                fill_random($urandom_range(10));
                add_element(8'($urandom()), elem_q.size());
            end
        endcase
    endfunction

    task automatic send_frame(int blen, int cut);
        for (int i = 0; i < cut; i++)
            send_byte(frame_q[i], i == 0, (i == 0) ? blen[BODY_LEN_W-1:0]
                                                   : BODY_LEN_W'($urandom()));
    endtask

    task automatic send_random_frame();
        int blen;
        int cut;
        frame_q.delete();
        repeat ($urandom_range(1, 4)) add_random_element();
        blen = frame_q.size();
        case ($urandom_range(19))
            15, 16: blen = $urandom_range(blen);
            17: blen = blen + $urandom_range(1, 5);
            18: blen = $urandom_range(4095);
            19: blen = ($urandom_range(1) != 0) ? 4095 : 0;
            default: ;
        endcase
        cut = ($urandom_range(9) == 0) ? $urandom_range(1, frame_q.size()) : frame_q.size();
        send_frame(blen, cut);
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 4))
            send_byte(8'($urandom()), $urandom_range(7) == 0, BODY_LEN_W'($urandom()));
    endtask

    task automatic random_part(int count);
        int start;
        start = items_sent;
        while (items_sent - start < count) begin
            if ($urandom_range(9) == 0)
                send_noise();
            else
                send_random_frame();
        end
    endtask

    initial begin
        logic [7:0] directed [23];
        directed = '{8'h00, 8'h02, 8'h48, 8'hFF,
                     8'h01, 8'h02, 8'h82, 8'h00,
                     8'h07, 8'h03, 8'h55, 8'h53, 8'h20,
                     8'h05, 8'h03, 8'h00, 8'h01, 8'hFF,
                     8'h05, 8'h01, 8'h00,
                     8'hDD, 8'h01};
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        configure(SSID_ID_RST, RATES_ID_RST, COUNTRY_ID_RST, TRAFFIC_ID_RST, SECURE_ID_RST,
                  STD_OUI_RST);
        // stray byte with no body open, then ssid, rates, country, DTIM, bad DTIM
        // length, and a type byte with only two bytes left
        send_byte(8'hA5, 1'b0, '0);
        foreach (directed[i])
            send_byte(directed[i], i == 0, (i == 0) ? BODY_LEN_W'(23) : '0);
        random_part(100);

        configure(8'd255, 8'd0, 8'd128, 8'd254, 8'd1, 24'hFFFFFF);
        // long ssid while the receiver holds off: the output fills and input stalls
        hold_req = 1'b1;
        frame_q.delete();
        elem_q.delete();
        fill_random(60);
        add_element(reg_id[CFG_SSID_ID], 60);
        send_frame(62, 62);
        random_part(100);

        // all ids equal, ssid takes priority; no idling on either side
        configure(8'd48, 8'd48, 8'd48, 8'd48, 8'd48, 24'h000000);
        in_idle_on = 1'b0;
        out_idle_on = 1'b0;
        random_part(100);
        in_idle_on = 1'b1;
        out_idle_on = 1'b1;

        // security shares its id with the traffic map and wins
        configure(8'h10, 8'h20, 8'h40, 8'h50, 8'h50, 24'($urandom()));
        random_part(100);

        configure(8'($urandom()), 8'($urandom()), 8'($urandom()), 8'($urandom()),
                  8'($urandom()), 24'($urandom()));
        random_part(100);

        in_valid <= 1'b0;
        while (sb.expected_records.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES + 4) @(negedge clk);
        if (sb.failures == 0 && sb.expected_records.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
